// ===== design/rvx_pkg.sv =====
// Package for the RV32I execute step core: sizes, opcodes, error codes,
// and the result record passed from the execute logic to writeback.
// No dependencies.
`timescale 1ns / 1ps
package rvx_pkg;
   localparam int DATA_WORDS = 4096;
   localparam int DMEM_AW = $clog2(DATA_WORDS);
   localparam int RF_AW = 5;
   localparam int RF_DEPTH = 32;

   localparam logic [4:0] OPC_LUI    = 5'b01101;
   localparam logic [4:0] OPC_AUIPC  = 5'b00101;
   localparam logic [4:0] OPC_JAL    = 5'b11011;
   localparam logic [4:0] OPC_JALR   = 5'b11001;
   localparam logic [4:0] OPC_OP     = 5'b01100;
   localparam logic [4:0] OPC_OPIMM  = 5'b00100;
   localparam logic [4:0] OPC_BRANCH = 5'b11000;
   localparam logic [4:0] OPC_LOAD   = 5'b00000;
   localparam logic [4:0] OPC_STORE  = 5'b01000;
   localparam logic [4:0] OPC_FENCE  = 5'b00011;
   localparam logic [4:0] SHAMT_MASK = 5'h1f;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_ILL   = 2'd1;
   localparam logic [1:0] ERR_ALIGN = 2'd2;
   localparam logic [1:0] ERR_RANGE = 2'd3;

   localparam logic [0:0] CSR_ENTRY = 1'b0;
   localparam logic [0:0] CSR_BASE  = 1'b1;

   typedef struct packed {
      logic [1:0]         err;
      logic [31:0]        npc;
      logic               wr;
      logic [31:0]        val;
      logic               is_load;
      logic               is_store;
      logic [2:0]         f3;
      logic [1:0]         boff;
      logic [DMEM_AW-1:0] widx;
      logic [31:0]        sdata;
      logic [3:0]         smask;
   } ex_res_type;
endpackage

// ===== design/rvx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/rvx_exec.sv =====
// Execute logic: decode, ALU, branch and address checks for one instruction.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
module rvx_exec
   import rvx_pkg::*;
(
   input  logic [31:0] instr,
   input  logic [31:0] pc,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] data_base,
   output ex_res_type  res
);
   logic [4:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] iimm, simm, bimm, jimm, op2, addr, off, tgt;
   logic [4:0]  sh;
   logic        take, lts, ltu;
   logic [1:0]  aerr;

   always_comb begin
      opc  = instr[6:2];
      f3   = instr[14:12];
      f7   = instr[31:25];
      iimm = {{20{instr[31]}}, instr[31:20]};
      simm = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      bimm = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
      jimm = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
      op2  = (opc == OPC_OP || opc == OPC_BRANCH) ? b : iimm;
      sh   = op2[4:0] & SHAMT_MASK;
      lts  = $signed(a) < $signed(op2);
      ltu  = a < op2;
      addr = a + ((opc == OPC_STORE) ? simm : iimm);
      off  = addr - data_base;
      aerr = ERR_OK;
      if ((f3[1:0] == 2'd1 && addr[0]) || (f3[1:0] == 2'd2 && addr[1:0] != 2'd0)) begin
         aerr = ERR_ALIGN;
      end else if (off[31:DMEM_AW+2] != '0) begin
         aerr = ERR_RANGE;
      end
      take = 1'b0;
      tgt  = pc + bimm;

      res          = '0;
      res.npc      = pc + 32'd4;
      res.f3       = f3;
      res.boff     = addr[1:0];
      res.widx     = off[DMEM_AW+1:2];
      res.sdata    = b << {addr[1:0], 3'b000};
      case (f3[1:0])
         2'd0:    res.smask = 4'b0001 << addr[1:0];
         2'd1:    res.smask = 4'b0011 << addr[1:0];
         default: res.smask = 4'b1111;
      endcase

      unique case (opc)
         OPC_LUI: begin
            res.wr  = 1'b1;
            res.val = {instr[31:12], 12'd0};
         end
         OPC_AUIPC: begin
            res.wr  = 1'b1;
            res.val = {instr[31:12], 12'd0} + pc;
         end
         OPC_JAL: begin
            res.wr  = 1'b1;
            res.val = pc + 32'd4;
            res.npc = pc + jimm;
            if (res.npc[1:0] != 2'd0) res.err = ERR_ALIGN;
         end
         OPC_JALR: begin
            res.wr  = 1'b1;
            res.val = pc + 32'd4;
            res.npc = (a + iimm) & ~32'd1;
            if (f3 != 3'd0) res.err = ERR_ILL;
            else if (res.npc[1]) res.err = ERR_ALIGN;
         end
         OPC_OP, OPC_OPIMM: begin
            res.wr = 1'b1;
            if (opc == OPC_OP && f7 == 7'h20 && f3 == 3'd0) begin
               res.val = a - b;
            end else if (f7 == 7'h20 && f3 == 3'd5) begin
               res.val = 32'($signed(a) >>> sh);
            end else if (f7 != 7'd0 && (opc == OPC_OP || f3 == 3'd1 || f3 == 3'd5)) begin
               res.err = ERR_ILL;
            end else begin
               case (f3)
                  3'd0:    res.val = a + op2;
                  3'd1:    res.val = a << sh;
                  3'd2:    res.val = {31'd0, lts};
                  3'd3:    res.val = {31'd0, ltu};
                  3'd4:    res.val = a ^ op2;
                  3'd5:    res.val = a >> sh;
                  3'd6:    res.val = a | op2;
                  default: res.val = a & op2;
               endcase
            end
         end
         OPC_BRANCH: begin
            case (f3)
               3'd0:    take = a == b;
               3'd1:    take = a != b;
               3'd4:    take = lts;
               3'd5:    take = !lts;
               3'd6:    take = ltu;
               3'd7:    take = !ltu;
               default: res.err = ERR_ILL;
            endcase
            if (res.err == ERR_OK && take) begin
               res.npc = tgt;
               if (tgt[1:0] != 2'd0) res.err = ERR_ALIGN;
            end
         end
         OPC_LOAD: begin
            res.wr = 1'b1;
            if (f3 == 3'd3 || f3 > 3'd5) res.err = ERR_ILL;
            else res.err = aerr;
            res.is_load = 1'b1;
         end
         OPC_STORE: begin
            if (f3 > 3'd2) res.err = ERR_ILL;
            else res.err = aerr;
            res.is_store = 1'b1;
         end
         OPC_FENCE: begin
            if (f3 != 3'd0) res.err = ERR_ILL;
         end
         default: res.err = ERR_ILL;
      endcase
      if (instr[1:0] != 2'b11) res.err = ERR_ILL;
   end
endmodule

// ===== design/rv32i_execute_step_core.sv =====
// Top level of the RV32I execute step core: register file and data memory RAMs,
// read/execute/writeback stages and the result register. Depends on rvx_pkg,
// rvx_ram and rvx_exec.
//
//  channel | direction | handshake              | beat
//  req_    | in        | req_valid / req_ready  | cmd, instr, load_index, load_word
//  rsp_    | out       | rsp_valid / rsp_ready  | pc, next pc, destination, error code
//  csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// An item passes from acceptance to result through register file read, execute with data
// memory read, then writeback. A new item is accepted only once the previous one has left
// execute, so its register file read overlaps the previous writeback; a forwarding register
// covers that overlap. Reset clears the register file valid bits, the program counter and
// all stage valids; data memory is not cleared. A stalled result holds writeback and input.
`timescale 1ns / 1ps
module rv32i_execute_step_core
   import rvx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_instr,
   input  logic [11:0] req_load_index,
   input  logic [31:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_instr_pc,
   output logic [31:0] rsp_next_pc,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_dest_written,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   logic [31:0] pc_ff, base_ff;
   logic [RF_DEPTH-1:0] rf_vld_ff;
   logic        ex_vld_ff, wb_vld_ff, out_vld_ff;
   logic        ex_cmd_ff, wb_cmd_ff;
   logic [31:0] ex_instr_ff;
   logic [11:0] ex_lidx_ff, wb_lidx_ff;
   logic [31:0] ex_lword_ff, wb_lword_ff;
   logic        a_ok_ff, b_ok_ff;
   logic        fwd_vld_ff;
   logic [4:0]  fwd_idx_ff;
   logic [31:0] fwd_val_ff;
   ex_res_type  wb_res_ff;
   logic [31:0] wb_pc_ff;
   logic [4:0]  wb_rd_ff;
   logic [31:0] out_pc_ff, out_npc_ff, out_val_ff;
   logic [4:0]  out_idx_ff;
   logic        out_wr_ff;
   logic [1:0]  out_err_ff;

   logic        accept, wb_adv, ex_adv;
   logic [31:0] rs1_rdata, rs2_rdata, a_val, b_val, dm_rdata;
   ex_res_type  ex_res;
   logic        rf_we, dm_we, cmd_hit;
   logic [31:0] wb_val, ld_word, dm_wdata;
   logic [DMEM_AW-1:0] dm_waddr;

   assign wb_adv    = wb_vld_ff && (!out_vld_ff || rsp_ready);
   assign ex_adv    = ex_vld_ff && (!wb_vld_ff || wb_adv);
   assign req_ready = !ex_vld_ff && (!wb_vld_ff || wb_adv);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
      .clock(clock), .we(rf_we), .waddr(wb_rd_ff), .wdata(wb_val),
      .re(accept), .raddr(req_instr[19:15]), .rdata(rs1_rdata));
   rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
      .clock(clock), .we(rf_we), .waddr(wb_rd_ff), .wdata(wb_val),
      .re(accept), .raddr(req_instr[24:20]), .rdata(rs2_rdata));

   always_comb begin
      a_val = a_ok_ff ? rs1_rdata : 32'd0;
      b_val = b_ok_ff ? rs2_rdata : 32'd0;
      if (fwd_vld_ff && fwd_idx_ff == ex_instr_ff[19:15]) a_val = fwd_val_ff;
      if (fwd_vld_ff && fwd_idx_ff == ex_instr_ff[24:20]) b_val = fwd_val_ff;
   end

   rvx_exec u_exec (
      .instr(ex_instr_ff), .pc(pc_ff), .a(a_val), .b(b_val),
      .data_base(base_ff), .res(ex_res));

   rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock(clock), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
      .re(ex_adv), .raddr(ex_res.widx), .rdata(dm_rdata));

   always_comb begin
      ld_word = dm_rdata >> {wb_res_ff.boff, 3'b000};
      case (wb_res_ff.f3)
         3'd0:    wb_val = {{24{ld_word[7]}}, ld_word[7:0]};
         3'd1:    wb_val = {{16{ld_word[15]}}, ld_word[15:0]};
         3'd4:    wb_val = {24'd0, ld_word[7:0]};
         3'd5:    wb_val = {16'd0, ld_word[15:0]};
         default: wb_val = dm_rdata;
      endcase
      if (!wb_res_ff.is_load) wb_val = wb_res_ff.val;
      for (int k = 0; k < 4; k++) begin
         dm_wdata[8*k +: 8] = wb_res_ff.smask[k] ? wb_res_ff.sdata[8*k +: 8]
                                                 : dm_rdata[8*k +: 8];
      end
      cmd_hit = {20'd0, wb_lidx_ff} < 32'(DATA_WORDS);
      dm_waddr = wb_res_ff.widx;
      if (wb_cmd_ff) begin
         dm_wdata = wb_lword_ff;
         dm_waddr = wb_lidx_ff[DMEM_AW-1:0];
      end
      rf_we = wb_adv && !wb_cmd_ff && wb_res_ff.err == ERR_OK && wb_res_ff.wr
              && wb_rd_ff != 5'd0;
      dm_we = wb_adv && (wb_cmd_ff ? cmd_hit
                                   : (wb_res_ff.err == ERR_OK && wb_res_ff.is_store));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff  <= 1'b0;
         wb_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         rf_vld_ff  <= '0;
         base_ff    <= 32'h8000_0000;
         pc_ff      <= 32'd0;
      end else begin
         if (accept) ex_vld_ff <= 1'b1;
         else if (ex_adv) ex_vld_ff <= 1'b0;
         if (ex_adv) wb_vld_ff <= 1'b1;
         else if (wb_adv) wb_vld_ff <= 1'b0;
         if (wb_adv) out_vld_ff <= 1'b1;
         else if (rsp_ready) out_vld_ff <= 1'b0;
         if (accept) fwd_vld_ff <= rf_we;
         if (rf_we) rf_vld_ff[wb_rd_ff] <= 1'b1;
         if (csr_valid && csr_index == CSR_ENTRY) begin
            pc_ff <= csr_wdata;
         end else if (wb_adv && !wb_cmd_ff && wb_res_ff.err == ERR_OK) begin
            pc_ff <= wb_res_ff.npc;
         end
         if (csr_valid && csr_index == CSR_BASE) base_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_cmd_ff   <= req_cmd;
         ex_instr_ff <= req_instr;
         ex_lidx_ff  <= req_load_index;
         ex_lword_ff <= req_load_word;
         a_ok_ff     <= rf_vld_ff[req_instr[19:15]];
         b_ok_ff     <= rf_vld_ff[req_instr[24:20]];
         fwd_idx_ff  <= wb_rd_ff;
         fwd_val_ff  <= wb_val;
      end
      if (ex_adv) begin
         wb_res_ff   <= ex_res;
         wb_cmd_ff   <= ex_cmd_ff;
         wb_pc_ff    <= pc_ff;
         wb_rd_ff    <= ex_instr_ff[11:7];
         wb_lidx_ff  <= ex_lidx_ff;
         wb_lword_ff <= ex_lword_ff;
      end
      if (wb_adv) begin
         out_pc_ff  <= wb_pc_ff;
         out_npc_ff <= wb_pc_ff;
         out_idx_ff <= 5'd0;
         out_val_ff <= 32'd0;
         out_wr_ff  <= 1'b0;
         out_err_ff <= ERR_OK;
         if (!wb_cmd_ff) begin
            out_err_ff <= wb_res_ff.err;
            if (wb_res_ff.err == ERR_OK) begin
               out_npc_ff <= wb_res_ff.npc;
               if (wb_res_ff.wr) begin
                  out_idx_ff <= wb_rd_ff;
                  if (wb_rd_ff != 5'd0) begin
                     out_val_ff <= wb_val;
                     out_wr_ff  <= 1'b1;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_instr_pc     = out_pc_ff;
   assign rsp_next_pc      = out_npc_ff;
   assign rsp_dest_index   = out_idx_ff;
   assign rsp_dest_value   = out_val_ff;
   assign rsp_dest_written = out_wr_ff;
   assign rsp_error_code   = out_err_ff;
endmodule

// ===== design/rvx_checker.sv =====
// Port-level checks for the RV32I execute step core, bound to the top level.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
module rvx_checker
   import rvx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_instr_pc,
   input logic [31:0] rsp_next_pc,
   input logic [4:0]  rsp_dest_index,
   input logic [31:0] rsp_dest_value,
   input logic        rsp_dest_written,
   input logic [1:0]  rsp_error_code
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result beat present after reset.");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("Stalled result beat changed.");
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |->
         rsp_next_pc == rsp_instr_pc && !rsp_dest_written && rsp_dest_index == 5'd0)
      else $error("Faulting beat changed state.");
   a_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_written |-> rsp_dest_index != 5'd0)
      else $error("Write reported for x0.");
   a_val_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_written |-> rsp_dest_value == 32'd0)
      else $error("Value reported without a write.");
endmodule

bind rv32i_execute_step_core rvx_checker u_rvx_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_instr_pc(rsp_instr_pc), .rsp_next_pc(rsp_next_pc),
   .rsp_dest_index(rsp_dest_index), .rsp_dest_value(rsp_dest_value),
   .rsp_dest_written(rsp_dest_written), .rsp_error_code(rsp_error_code));

// ===== verif/rv32i_execute_step_core_test.sv =====
// Self-checking testbench for rv32i_execute_step_core: an in-bench instruction
// predictor checks each response beat under several idle, stall and CSR settings.
// Depends on rvx_pkg and the core RTL.
`timescale 1ns / 1ps
module rv32i_execute_step_core_test;
   import rvx_pkg::*;

   typedef struct packed {
      logic [31:0] instr_pc;
      logic [31:0] next_pc;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        dest_written;
      logic [1:0]  error_code;
   } step_result_type;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;
   localparam int QUIET_LIMIT = 4000;
   localparam int PRELOAD_WORDS = 128;
   localparam logic [4:0] OPC_SYSTEM = 5'b11100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [31:0] req_instr = '0;
   logic [11:0] req_load_index = '0;
   logic [31:0] req_load_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_instr_pc;
   logic [31:0] rsp_next_pc;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic        rsp_dest_written;
   logic [1:0]  rsp_error_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   logic [31:0]  gpr [32];
   logic [31:0]  pc_q;
   logic [31:0]  dbase_q;
   logic [31:0]  dmem [DATA_WORDS];
   bit           dmem_written [DATA_WORDS];
   step_result_type expected_steps [$];
   int           errors = 0;
   int           idle_mode = IDLE_NONE;
   int           quiet = 0;

   rv32i_execute_step_core dut (.*);

   always #10 clock = ~clock;

   function automatic logic [1:0] check_access(logic [31:0] addr, int size, output int w);
      logic [31:0] off;
      w = 0;
      if ((addr & (size - 1)) != 0) return ERR_ALIGN;
      off = addr - dbase_q;
      if (off >= 32'(DATA_WORDS * 4)) return ERR_RANGE;
      w = int'(off >> 2);
      return ERR_OK;
   endfunction

   function automatic int access_size(logic [2:0] f3);
      return (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
   endfunction

   // True when the instruction would read a data word that was never written.
   function automatic bit reads_unwritten(logic [31:0] ins);
      logic [31:0] a;
      logic [2:0]  f3;
      int          w;
      a = gpr[ins[19:15]];
      f3 = ins[14:12];
      if (ins[1:0] != 2'b11) return 0;
      if (ins[6:2] == OPC_LOAD && f3 != 3'd3 && f3 <= 3'd5) begin
         if (check_access(a + {{20{ins[31]}}, ins[31:20]}, access_size(f3), w) == ERR_OK)
            return !dmem_written[w];
      end else if (ins[6:2] == OPC_STORE && f3 < 3'd2) begin
         if (check_access(a + {{20{ins[31]}}, ins[31:25], ins[11:7]}, access_size(f3), w)
             == ERR_OK)
            return !dmem_written[w];
      end
      return 0;
   endfunction

   function automatic step_result_type execute_step(bit cmd, logic [31:0] ins,
                                                    logic [11:0] li, logic [31:0] lw);
      step_result_type r;
      logic [4:0]  opc, rd, sh;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a, b, iimm, simm, bimm, jimm, npc, val, addr, m, word;
      bit          wr, take;
      logic [1:0]  err;
      int          w, sft;
      r = '0;
      r.instr_pc = pc_q;
      r.next_pc = pc_q;
      if (cmd) begin
         if (li < DATA_WORDS) begin
            dmem[li] = lw;
            dmem_written[li] = 1;
         end
         return r;
      end
      opc = ins[6:2];
      f3 = ins[14:12];
      f7 = ins[31:25];
      rd = ins[11:7];
      a = gpr[ins[19:15]];
      b = gpr[ins[24:20]];
      iimm = {{20{ins[31]}}, ins[31:20]};
      simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      bimm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      jimm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      npc = pc_q + 32'd4;
      val = '0;
      wr = 0;
      take = 0;
      w = 0;
      err = ERR_OK;
      if (ins[1:0] != 2'b11) begin
         err = ERR_ILL;
      end else begin
         case (opc)
            OPC_LUI: begin
               val = {ins[31:12], 12'd0};
               wr = 1;
            end
            OPC_AUIPC: begin
               val = {ins[31:12], 12'd0} + pc_q;
               wr = 1;
            end
            OPC_JAL: begin
               npc = pc_q + jimm;
               val = pc_q + 32'd4;
               wr = 1;
               if (npc[1:0] != 0) err = ERR_ALIGN;
            end
            OPC_JALR: begin
               npc = (a + iimm) & ~32'd1;
               val = pc_q + 32'd4;
               wr = 1;
               if (f3 != 0) err = ERR_ILL;
               else if (npc[1:0] != 0) err = ERR_ALIGN;
            end
            OPC_OP: begin
               sh = b[4:0] & SHAMT_MASK;
               wr = 1;
               if (f7 == 7'h20 && f3 == 3'd0) val = a - b;
               else if (f7 == 7'h20 && f3 == 3'd5) val = $signed(a) >>> sh;
               else if (f7 != 0) err = ERR_ILL;
               else begin
                  case (f3)
                     3'd0: val = a + b;
                     3'd1: val = a << sh;
                     3'd2: val = {31'd0, $signed(a) < $signed(b)};
                     3'd3: val = {31'd0, a < b};
                     3'd4: val = a ^ b;
                     3'd5: val = a >> sh;
                     3'd6: val = a | b;
                     default: val = a & b;
                  endcase
               end
            end
            OPC_OPIMM: begin
               sh = iimm[4:0] & SHAMT_MASK;
               wr = 1;
               case (f3)
                  3'd0: val = a + iimm;
                  3'd1: begin
                     if (f7 != 0) err = ERR_ILL;
                     else val = a << sh;
                  end
                  3'd2: val = {31'd0, $signed(a) < $signed(iimm)};
                  3'd3: val = {31'd0, a < iimm};
                  3'd4: val = a ^ iimm;
                  3'd5: begin
                     if (f7 == 7'h20) val = $signed(a) >>> sh;
                     else if (f7 == 0) val = a >> sh;
                     else err = ERR_ILL;
                  end
                  3'd6: val = a | iimm;
                  default: val = a & iimm;
               endcase
            end
            OPC_BRANCH: begin
               case (f3)
                  3'd0: take = (a == b);
                  3'd1: take = (a != b);
                  3'd4: take = $signed(a) < $signed(b);
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = a < b;
                  3'd7: take = a >= b;
                  default: err = ERR_ILL;
               endcase
               if (err == ERR_OK && take) begin
                  npc = pc_q + bimm;
                  if (npc[1:0] != 0) err = ERR_ALIGN;
               end
            end
            OPC_LOAD: begin
               addr = a + iimm;
               wr = 1;
               if (f3 == 3'd3 || f3 > 3'd5) err = ERR_ILL;
               else begin
                  err = check_access(addr, access_size(f3), w);
                  if (err == ERR_OK) begin
                     sft = addr[1:0] * 8;
                     word = dmem[w] >> sft;
                     case (f3)
                        3'd0: val = {{24{word[7]}}, word[7:0]};
                        3'd1: val = {{16{word[15]}}, word[15:0]};
                        3'd2: val = word;
                        3'd4: val = {24'd0, word[7:0]};
                        default: val = {16'd0, word[15:0]};
                     endcase
                  end
               end
            end
            OPC_STORE: begin
               addr = a + simm;
               if (f3 > 3'd2) err = ERR_ILL;
               else begin
                  err = check_access(addr, access_size(f3), w);
                  if (err == ERR_OK) begin
                     sft = addr[1:0] * 8;
                     m = (f3 == 3'd0) ? 32'hFF : ((f3 == 3'd1) ? 32'hFFFF : 32'hFFFF_FFFF);
                     m = m << sft;
                     dmem[w] = (dmem[w] & ~m) | ((b << sft) & m);
                     dmem_written[w] = 1;
                  end
               end
            end
            OPC_FENCE: if (f3 != 0) err = ERR_ILL;
            default: err = ERR_ILL;
         endcase
      end
      if (err != ERR_OK) begin
         r.error_code = err;
         return r;
      end
      pc_q = npc;
      r.next_pc = npc;
      if (wr) begin
         r.dest_index = rd;
         if (rd != 0) begin
            gpr[rd] = val;
            r.dest_value = val;
            r.dest_written = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SEND) return $urandom_range(99) < 75;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 11;
      return 0;
   endfunction

   function automatic bit receiver_ready();
      if (idle_mode == IDLE_RECV) return $urandom_range(99) >= 75;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) >= 11;
      return 1;
   endfunction

   task automatic send_beat(bit cmd, logic [31:0] ins, logic [11:0] li, logic [31:0] lw);
      while (sender_idles()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_instr = ins;
      req_load_index = li;
      req_load_word = lw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_steps.push_back(execute_step(cmd, ins, li, lw));
      @(negedge clock);
   endtask

   task automatic send_instr(logic [31:0] ins);
      if (!reads_unwritten(ins)) send_beat(1'b0, ins, 12'($urandom), $urandom);
   endtask

   function automatic logic [31:0] enc_i(logic [4:0] opc, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, opc, 2'b11};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_OP, 2'b11};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE, 2'b11};
   endfunction

   function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH, 2'b11};
   endfunction

   function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL, 2'b11};
   endfunction

   task automatic load_const(logic [4:0] rd, logic [31:0] v);
      logic [31:0] hi;
      hi = v + 32'h800;
      send_instr({hi[31:12], rd, OPC_LUI, 2'b11});
      send_instr(enc_i(OPC_OPIMM, rd, 3'd0, rd, v[11:0]));
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      wait_drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ENTRY) pc_q = data;
      else dbase_q = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(negedge clock) rsp_ready = receiver_ready();

   always @(posedge clock) begin
      step_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            $error("response beat with no expected result");
            errors++;
         end else begin
            e = expected_steps.pop_front();
            check_field("instr_pc", e.instr_pc, rsp_instr_pc);
            check_field("next_pc", e.next_pc, rsp_next_pc);
            check_field("dest_index", 32'(e.dest_index), 32'(rsp_dest_index));
            check_field("dest_value", e.dest_value, rsp_dest_value);
            check_field("dest_written", 32'(e.dest_written), 32'(rsp_dest_written));
            check_field("error_code", 32'(e.error_code), 32'(rsp_error_code));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_preload();
      for (int i = 0; i < PRELOAD_WORDS; i++) send_beat(1'b1, $urandom, 12'(i), $urandom);
   endtask

   task automatic test_directed();
      send_beat(1'b1, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
      send_beat(1'b1, '0, 12'(PRELOAD_WORDS - 1), 32'h8000_0001);
      send_instr({20'hFFFFF, 5'd1, OPC_LUI, 2'b11});
      send_instr({20'h80000, 5'd2, OPC_AUIPC, 2'b11});
      send_instr(enc_i(OPC_OPIMM, 5'd0, 3'd0, 5'd0, 12'd1));
      load_const(5'd3, 32'h8000_0000);
      send_instr(enc_r(7'h20, 5'd3, 5'd0, 3'd0, 5'd4));
      send_instr(enc_i(OPC_OPIMM, 5'd6, 3'd0, 5'd0, 12'd31));
      send_instr(enc_r(7'h20, 5'd6, 5'd3, 3'd5, 5'd5));
      send_instr(enc_i(OPC_OPIMM, 5'd7, 3'd5, 5'd3, 12'h404));
      send_instr(enc_i(OPC_OPIMM, 5'd8, 3'd3, 5'd0, 12'hFFF));
      send_instr(enc_i(OPC_OPIMM, 5'd9, 3'd1, 5'd3, 12'h401));
      send_instr(enc_r(7'h01, 5'd6, 5'd3, 3'd0, 5'd9));
      send_instr(32'h0000_0010);
      send_instr(32'h0000_0073);
      send_instr(enc_i(OPC_FENCE, 5'd0, 3'd1, 5'd0, 12'd0));
      send_instr(enc_i(OPC_FENCE, 5'd0, 3'd0, 5'd0, 12'h0FF));
      send_instr(enc_i(OPC_JALR, 5'd1, 3'd1, 5'd0, 12'd0));
      send_instr(enc_j(21'd2, 5'd1));
      send_instr(enc_b(13'd8, 5'd0, 5'd0, 3'd2));
      send_instr(enc_i(OPC_LOAD, 5'd9, 3'd3, 5'd3, 12'd0));
      send_instr(enc_s(12'd0, 5'd6, 5'd3, 3'd4));
      send_instr(enc_i(OPC_LOAD, 5'd9, 3'd1, 5'd3, 12'd1));
      send_instr(enc_i(OPC_LOAD, 5'd9, 3'd2, 5'd3, 12'hFFC));
      send_instr(enc_i(OPC_LOAD, 5'd9, 3'd2, 5'd3, 12'd4));
      send_instr(enc_s(12'd1, 5'd6, 5'd3, 3'd0));
      send_instr(enc_i(OPC_LOAD, 5'd10, 3'd4, 5'd3, 12'd1));
      send_instr(enc_j(21'd8, 5'd1));
   endtask

   task automatic random_memory_access();
      logic [4:0]  rs1;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [31:0] target;
      bit          is_load;
      rs1 = 5'($urandom_range(1, 31));
      is_load = $urandom_range(1);
      f3 = is_load ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(9) < 8)
         f3 = is_load ? 3'({$urandom_range(1), 2'($urandom_range(0, 2))} & 3'b101 |
                           3'($urandom_range(0, 1) ? 3'd2 & {3{f3 == 3'd2}} : 3'd0))
                      : 3'($urandom_range(0, 2));
      imm = 12'($signed($urandom_range(0, 63)) - 32);
      if ($urandom_range(99) < 85) begin
         target = dbase_q + $urandom_range(0, PRELOAD_WORDS * 4 - 1);
         if ($urandom_range(99) < 80) target = target & ~32'(access_size(f3) - 1);
      end else begin
         target = $urandom;
      end
      load_const(rs1, target - {{20{imm[11]}}, imm});
      if (is_load) send_instr(enc_i(OPC_LOAD, 5'($urandom), f3, rs1, imm));
      else send_instr(enc_s(imm, 5'($urandom), rs1, f3));
   endtask

   task automatic random_control_flow();
      logic [12:0] bimm;
      logic [20:0] jimm;
      logic [11:0] iimm;
      bimm = 13'($urandom);
      jimm = 21'($urandom);
      iimm = 12'($urandom);
      if ($urandom_range(9) < 8) begin
         bimm[1:0] = 2'd0;
         jimm[1:0] = 2'd0;
         iimm[1:0] = 2'd0;
      end
      case ($urandom_range(2))
         0: send_instr(enc_b(bimm, 5'($urandom), 5'($urandom), 3'($urandom)));
         1: send_instr(enc_j(jimm, 5'($urandom)));
         default: send_instr(enc_i(OPC_JALR, 5'($urandom),
                                   ($urandom_range(9) < 8) ? 3'd0 : 3'($urandom),
                                   5'($urandom), iimm));
      endcase
   endtask

   task automatic random_alu();
      logic [6:0]  f7;
      logic [31:0] seeds [4];
      seeds = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      case ($urandom_range(4))
         0: f7 = 7'h20;
         1: f7 = 7'($urandom);
         default: f7 = 7'h00;
      endcase
      case ($urandom_range(9))
         0: send_instr({20'($urandom), 5'($urandom), OPC_LUI, 2'b11});
         1: send_instr({20'($urandom), 5'($urandom), OPC_AUIPC, 2'b11});
         2: load_const(5'($urandom), ($urandom_range(1)) ? seeds[$urandom_range(3)] : $urandom);
         3, 4, 5: send_instr(enc_r(f7, 5'($urandom), 5'($urandom), 3'($urandom),
                                   5'($urandom)));
         default: send_instr(enc_i(OPC_OPIMM, 5'($urandom), 3'($urandom), 5'($urandom),
                                   {f7, 5'($urandom)}));
      endcase
   endtask

   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 5) send_beat(1'b1, $urandom, 12'($urandom), $urandom);
         else if (pick < 12) send_instr($urandom);
         else if (pick < 40) random_memory_access();
         else if (pick < 55) random_control_flow();
         else if (pick < 95) random_alu();
         else send_instr(enc_i($urandom_range(1) ? OPC_FENCE : OPC_SYSTEM, 5'($urandom),
                               3'($urandom_range(0, 1)), 5'($urandom), 12'($urandom)));
      end
   endtask

   initial begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem_written[i]) dmem_written[i] = 0;
      pc_q = '0;
      dbase_q = 32'h8000_0000;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_preload();
      test_directed();
      write_csr(CSR_BASE, 32'h0);
      write_csr(CSR_ENTRY, 32'hFFFF_FFFC);
      idle_mode = IDLE_NONE;
      test_random(120);
      write_csr(CSR_BASE, 32'hFFFF_C000);
      write_csr(CSR_ENTRY, 32'h0000_1000);
      idle_mode = IDLE_SEND;
      test_random(120);
      write_csr(CSR_BASE, $urandom & ~32'h3);
      write_csr(CSR_ENTRY, 32'hFFFF_FFFF);
      idle_mode = IDLE_RECV;
      test_random(120);
      write_csr(CSR_BASE, 32'h8000_0000);
      write_csr(CSR_ENTRY, $urandom);
      idle_mode = IDLE_BOTH;
      test_random(120);
      wait_drain();
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
